@@ design/ncp_pkg.sv @@
// ============================================================================
// ncp_pkg
// Shared constants, types and helpers of the NURBS curve point evaluator.
// ============================================================================
package ncp_pkg;

    // Store sizes.
    localparam int MAX_POINTS = 16;
    localparam int MAX_DEGREE = 3;
    localparam int MAX_KNOTS  = 20;
    localparam int BASIS_LEN  = MAX_POINTS + MAX_DEGREE;

    // Field widths fixed by the interface.
    localparam int REQ_W      = 2;
    localparam int SLOT_W     = 5;
    localparam int PARAM_W    = 24;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int DEG_CFG_W  = 2;
    localparam int PTS_CFG_W  = 5;

    // Index and counter widths.
    localparam int KN_W = $clog2(MAX_KNOTS);
    localparam int PN_W = $clog2(MAX_POINTS);
    localparam int J_W  = $clog2(BASIS_LEN);
    localparam int L_W  = $clog2(MAX_DEGREE + 1);
    localparam int N_W  = $clog2(MAX_POINTS + 1);
    localparam int KA_W = $clog2(BASIS_LEN + MAX_DEGREE + 1);

    // Arithmetic widths.
    localparam int BASIS_W    = 32;
    localparam int BASIS_FRAC = 30;
    localparam int QFRAC      = 16;
    localparam int DIFF_W     = PARAM_W + 1;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = COORD_W + 2 + $clog2(MAX_POINTS);
    localparam int NUM_A      = BASIS_W + DIFF_W;
    localparam int NUM_W      = (ACC_W + QFRAC > NUM_A) ? ACC_W + QFRAC : NUM_A;
    localparam int DEN_W      = (ACC_W > DIFF_W) ? ACC_W : DIFF_W;
    localparam int QUOT_W     = NUM_W + 1;
    localparam int TACC_W     = NUM_W + 2;

    localparam logic signed [BASIS_W-1:0] BASIS_ONE = 32'sh4000_0000;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'd1;
    localparam logic [DEG_CFG_W-1:0] DEG_RESET  = 2'd3;
    localparam logic [PTS_CFG_W-1:0] PTS_RESET  = 5'd4;

    // Coordinate lanes.
    localparam logic [1:0] CO_X = 2'd0;
    localparam logic [1:0] CO_Y = 2'd1;
    localparam logic [1:0] CO_Z = 2'd2;
    localparam logic [1:0] CO_W = 2'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_KNOT  = 2'd0,
        REQ_POINT = 2'd1,
        REQ_EVAL  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KS_I,
        KS_ID,
        KS_I1,
        KS_ID1
    } t_ksel;

    typedef enum logic [1:0] {
        BS_KEEP,
        BS_SPAN,
        BS_SAT,
        BS_ZERO
    } t_bsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STEP,
        S_KRD,
        S_KCAP,
        S_T0M,
        S_T0D,
        S_T0W,
        S_T1M,
        S_T1D,
        S_T1W,
        S_SHIFT,
        S_PSTEP,
        S_PRD,
        S_PMUL,
        S_PADD,
        S_RCHK,
        S_RDIV,
        S_RWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              wr_knot;
        logic              wr_point;
        logic              u_ld;
        logic              k_rd;
        logic [KA_W-1:0]   k_addr;
        logic              k_cap;
        t_ksel             k_sel;
        logic              t_clr;
        logic              mul_lo;
        logic              mul_hi;
        logic              div_t0;
        logic              div_t1;
        logic              t_add;
        logic              b_shift;
        t_bsel             b_sel;
        logic              a_clr;
        logic              p_rd;
        logic [PN_W-1:0]   p_addr;
        logic              p_mul;
        logic              a_add;
        logic [1:0]        coord;
        logic              div_r;
        logic              r_ld;
        logic              o_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic den0_zero;
        logic den1_zero;
        logic sw_zero;
    } t_dp_stat;

    // Clamp a wide signed value into the 32-bit signed range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [TACC_W-1:0] v);
        logic [TACC_W-COORD_W:0] hi;
        hi = v[TACC_W-1:COORD_W-1];
        if ((&hi) || !(|hi)) begin
            return v[COORD_W-1:0];
        end else if (v[TACC_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ design/nurbs_curve_point_eval.sv @@
// ============================================================================
// nurbs_curve_point_eval
// Point on a rational B-spline curve by Cox-de Boor recursion, with knot and
// homogeneous control point stores loaded through the request channel.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready    req_type, slot, param, x y z w
//  out       source     o_out_valid / i_out_ready  curve x y z, weight_zero
//  cfg       sink       i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// A knot or control point write request gives no result.
// An evaluate request walks (degree+1) levels of the basis line, each of
// MAX_POINTS+MAX_DEGREE steps; an active step reads four knots and, above
// level zero, takes up to two passes of the one-bit-per-cycle divider.
// Then each control point is accumulated, and unless the weight sum is zero
// three more divider passes follow, one per coordinate.
// Reset is synchronous and active low; the stores need no clearing pass.
// A finished result sits in the output register while the next request is
// taken; only the hand-off of a new result waits for that register to drain.
//
module nurbs_curve_point_eval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ncp_pkg::REQ_W-1:0]          i_req_type,
    input  logic [ncp_pkg::SLOT_W-1:0]         i_slot,
    input  logic [ncp_pkg::PARAM_W-1:0]        i_param_value,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_z,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_w,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_x,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_y,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_z,
    output logic                               o_weight_zero,
    input  logic                               i_cfg_we,
    input  logic [ncp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ncp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ncp_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The sequencer owns the configuration registers, the level and step
    // counters and the output valid flag.
    ncp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the stores, the rotating basis line, the shared
    // multiplier and divider, and the result payload register.
    ncp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_slot        (i_slot),
        .i_param_value (i_param_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_point_w     (i_point_w),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_curve_z     (o_curve_z),
        .o_weight_zero (o_weight_zero)
    );

endmodule

@@ design/ncp_div.sv @@
// ============================================================================
// ncp_div
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// ============================================================================
module ncp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ncp_pkg::NUM_W-1:0]  i_num,
    input  logic signed [ncp_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [ncp_pkg::QUOT_W-1:0] o_quot
);
    import ncp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   sh_sub;
    logic             ge;

    assign num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    assign sh      = {r_rem, r_q[NUM_W-1]};
    assign sh_sub  = sh - {1'b0, r_den};
    assign ge      = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? sh_sub[DEN_W-1:0] : sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

@@ design/ncp_datapath.sv @@
// ============================================================================
// ncp_datapath
// Knot and control point stores, basis shift line, multiplier, accumulators,
// shared divider and output register.
// ============================================================================
module ncp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ncp_pkg::t_dp_cmd                   i_cmd,
    output ncp_pkg::t_dp_stat                  o_stat,
    input  logic [ncp_pkg::SLOT_W-1:0]         i_slot,
    input  logic [ncp_pkg::PARAM_W-1:0]        i_param_value,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_z,
    input  logic signed [ncp_pkg::COORD_W-1:0] i_point_w,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_x,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_y,
    output logic signed [ncp_pkg::COORD_W-1:0] o_curve_z,
    output logic                               o_weight_zero
);
    import ncp_pkg::*;

    logic [PARAM_W-1:0] knot_mem [MAX_KNOTS];
    logic [COORD_W-1:0] px_mem [MAX_POINTS];
    logic [COORD_W-1:0] py_mem [MAX_POINTS];
    logic [COORD_W-1:0] pz_mem [MAX_POINTS];
    logic [COORD_W-1:0] pw_mem [MAX_POINTS];

    logic [PARAM_W-1:0]        r_kdata;
    logic                      r_kok;
    logic [PARAM_W-1:0]        r_u;
    logic [PARAM_W-1:0]        r_ki;
    logic [PARAM_W-1:0]        r_kid;
    logic [PARAM_W-1:0]        r_ki1;
    logic [PARAM_W-1:0]        r_kid1;
    logic signed [COORD_W-1:0] r_pt [4];
    logic signed [BASIS_W-1:0] r_b [BASIS_LEN];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TACC_W-1:0]  r_tacc;
    logic signed [ACC_W-1:0]   r_acc [4];
    logic signed [COORD_W-1:0] r_res_x;
    logic signed [COORD_W-1:0] r_res_y;
    logic signed [COORD_W-1:0] r_res_z;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] r_out_z;
    logic                      r_out_wz;

    logic [PARAM_W-1:0]        knot_rd;
    logic signed [DIFF_W-1:0]  d_u_ki;
    logic signed [DIFF_W-1:0]  d_kid1_u;
    logic signed [DIFF_W-1:0]  den0;
    logic signed [DIFF_W-1:0]  den1;
    logic                      span;
    logic signed [BASIS_W-1:0] new_b;
    logic signed [PROD_W-1:0]  pt_sh;
    logic signed [PROD_W-1:0]  pt_term;
    logic                      pt_rnd;
    logic                      div_start;
    logic signed [NUM_W-1:0]   div_num;
    logic signed [DEN_W-1:0]   div_den;
    logic                      div_done;
    logic signed [QUOT_W-1:0]  div_quot;
    logic signed [COORD_W-1:0] quot_sat;

    // Stores: write on request, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_knot && (32'(i_slot) < MAX_KNOTS)) begin
            knot_mem[KN_W'(i_slot)] <= i_param_value;
        end
        if (i_cmd.k_rd) begin
            r_kok   <= (32'(i_cmd.k_addr) < MAX_KNOTS);
            r_kdata <= knot_mem[KN_W'(i_cmd.k_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && (32'(i_slot) < MAX_POINTS)) begin
            px_mem[PN_W'(i_slot)] <= i_point_x;
            py_mem[PN_W'(i_slot)] <= i_point_y;
            pz_mem[PN_W'(i_slot)] <= i_point_z;
            pw_mem[PN_W'(i_slot)] <= i_point_w;
        end
        if (i_cmd.p_rd) begin
            r_pt[CO_X] <= px_mem[i_cmd.p_addr];
            r_pt[CO_Y] <= py_mem[i_cmd.p_addr];
            r_pt[CO_Z] <= pz_mem[i_cmd.p_addr];
            r_pt[CO_W] <= pw_mem[i_cmd.p_addr];
        end
    end

    // A knot index past the store reads as zero.
    assign knot_rd = r_kok ? r_kdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.u_ld) begin
            r_u <= i_param_value;
        end
        if (i_cmd.k_cap) begin
            case (i_cmd.k_sel)
                KS_I:    r_ki   <= knot_rd;
                KS_ID:   r_kid  <= knot_rd;
                KS_I1:   r_ki1  <= knot_rd;
                KS_ID1:  r_kid1 <= knot_rd;
                default: r_ki   <= knot_rd;
            endcase
        end
    end

    assign d_u_ki   = $signed({1'b0, r_u})    - $signed({1'b0, r_ki});
    assign d_kid1_u = $signed({1'b0, r_kid1}) - $signed({1'b0, r_u});
    assign den0     = $signed({1'b0, r_kid})  - $signed({1'b0, r_ki});
    assign den1     = $signed({1'b0, r_kid1}) - $signed({1'b0, r_ki1});
    assign span     = (r_ki <= r_u) && (r_u < r_ki1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(r_b[0] * d_u_ki);
        end else if (i_cmd.mul_hi) begin
            r_prod <= PROD_W'(r_b[1] * d_kid1_u);
        end else if (i_cmd.p_mul) begin
            r_prod <= PROD_W'(r_b[0] * r_pt[i_cmd.coord]);
        end
    end

    // Divider operand selection.
    always_comb begin
        div_start = i_cmd.div_t0 || i_cmd.div_t1 || i_cmd.div_r;
        if (i_cmd.div_r) begin
            div_num = NUM_W'($signed({r_acc[i_cmd.coord], {QFRAC{1'b0}}}));
            div_den = DEN_W'(r_acc[CO_W]);
        end else begin
            div_num = NUM_W'($signed(r_prod[NUM_A-1:0]));
            div_den = i_cmd.div_t0 ? DEN_W'(den0) : DEN_W'(den1);
        end
    end

    ncp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign quot_sat = sat32(TACC_W'(div_quot));

    always_ff @(posedge i_clk) begin
        if (i_cmd.t_clr) begin
            r_tacc <= '0;
        end else if (i_cmd.t_add) begin
            r_tacc <= r_tacc + TACC_W'(div_quot);
        end
    end

    // Basis line rotates by one entry per step.
    always_comb begin
        case (i_cmd.b_sel)
            BS_KEEP: new_b = r_b[0];
            BS_SPAN: new_b = span ? BASIS_ONE : '0;
            BS_SAT:  new_b = sat32(r_tacc);
            default: new_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_shift) begin
            for (int i = 0; i < BASIS_LEN - 1; i++) begin
                r_b[i] <= r_b[i+1];
            end
            r_b[BASIS_LEN-1] <= new_b;
        end
    end

    // Q46 product back to Q16.16, truncated toward zero.
    assign pt_sh   = r_prod >>> BASIS_FRAC;
    assign pt_rnd  = r_prod[PROD_W-1] && (|r_prod[BASIS_FRAC-1:0]);
    assign pt_term = pt_sh + $signed(PROD_W'(pt_rnd));

    always_ff @(posedge i_clk) begin
        if (i_cmd.a_clr) begin
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_cmd.a_add) begin
            r_acc[i_cmd.coord] <= r_acc[i_cmd.coord] + ACC_W'(pt_term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.r_ld) begin
            case (i_cmd.coord)
                CO_X:    r_res_x <= quot_sat;
                CO_Y:    r_res_y <= quot_sat;
                CO_Z:    r_res_z <= quot_sat;
                default: r_res_z <= r_res_z;
            endcase
        end
        if (i_cmd.o_ld) begin
            r_out_wz <= o_stat.sw_zero;
            r_out_x  <= o_stat.sw_zero ? '0 : r_res_x;
            r_out_y  <= o_stat.sw_zero ? '0 : r_res_y;
            r_out_z  <= o_stat.sw_zero ? '0 : r_res_z;
        end
    end

    always_comb begin
        o_stat.div_done  = div_done;
        o_stat.den0_zero = (den0 == '0);
        o_stat.den1_zero = (den1 == '0);
        o_stat.sw_zero   = (r_acc[CO_W] == '0);
    end

    assign o_curve_x     = r_out_x;
    assign o_curve_y     = r_out_y;
    assign o_curve_z     = r_out_z;
    assign o_weight_zero = r_out_wz;

endmodule

@@ design/ncp_ctrl.sv @@
// ============================================================================
// ncp_ctrl
// Sequencer of the evaluator: configuration registers, step counters and
// the state machine that drives the datapath.
// ============================================================================
module ncp_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ncp_pkg::REQ_W-1:0]        i_req_type,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_cfg_we,
    input  logic [ncp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ncp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ncp_pkg::t_dp_stat                i_stat,
    output ncp_pkg::t_dp_cmd                 o_cmd
);
    import ncp_pkg::*;

    t_state               r_state, n_state;
    logic [J_W-1:0]       r_j, n_j;
    logic [L_W-1:0]       r_lvl, n_lvl;
    t_ksel                r_ks, n_ks;
    logic [1:0]           r_c, n_c;
    logic                 r_out_valid, n_out_valid;
    logic [DEG_CFG_W-1:0] r_cfg_deg;
    logic [PTS_CFG_W-1:0] r_cfg_pts;

    logic [L_W-1:0]  deg_eff;
    logic [N_W-1:0]  n_eff;
    logic [KA_W-1:0] total;
    logic [KA_W-1:0] j_lvl;
    logic            active;
    logic            last_j;
    logic            last_lvl;
    logic            accept;
    logic            out_free;
    t_bsel           shift_sel;

    assign deg_eff  = (32'(r_cfg_deg) > MAX_DEGREE) ? L_W'(MAX_DEGREE) : L_W'(r_cfg_deg);
    assign n_eff    = (32'(r_cfg_pts) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(r_cfg_pts);
    assign total    = KA_W'(n_eff) + KA_W'(deg_eff);
    assign j_lvl    = KA_W'(r_j) + KA_W'(r_lvl);
    assign active   = (j_lvl < total);
    assign last_j   = (32'(r_j) == BASIS_LEN - 1);
    assign last_lvl = (r_lvl == deg_eff);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Level zero builds the span indicator, later levels take the clamped sum.
    always_comb begin
        if (r_lvl == '0) begin
            shift_sel = active ? BS_SPAN : BS_ZERO;
        end else begin
            shift_sel = active ? BS_SAT : BS_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_lvl       <= '0;
            r_ks        <= KS_I;
            r_c         <= CO_X;
            r_out_valid <= 1'b0;
            r_cfg_deg   <= DEG_RESET;
            r_cfg_pts   <= PTS_RESET;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_lvl       <= n_lvl;
            r_ks        <= n_ks;
            r_c         <= n_c;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEGREE: r_cfg_deg <= i_cfg_data[DEG_CFG_W-1:0];
                    CFG_POINTS: r_cfg_pts <= i_cfg_data[PTS_CFG_W-1:0];
                    default:    r_cfg_pts <= r_cfg_pts;
                endcase
            end
        end
    end

    // Next state and counters.
    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_lvl       = r_lvl;
        n_ks        = r_ks;
        n_c         = r_c;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_EVAL)) begin
                    n_j     = '0;
                    n_lvl   = '0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (active) begin
                    n_ks    = KS_I;
                    n_state = S_KRD;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_KRD: n_state = S_KCAP;
            S_KCAP: begin
                case (r_ks)
                    KS_I:    n_ks = KS_ID;
                    KS_ID:   n_ks = KS_I1;
                    KS_I1:   n_ks = KS_ID1;
                    default: n_ks = KS_I;
                endcase
                if (r_ks == KS_ID1) begin
                    n_state = (r_lvl == '0) ? S_SHIFT : S_T0M;
                end else begin
                    n_state = S_KRD;
                end
            end
            S_T0M: n_state = i_stat.den0_zero ? S_T1M : S_T0D;
            S_T0D: n_state = S_T0W;
            S_T0W: begin
                if (i_stat.div_done) begin
                    n_state = S_T1M;
                end
            end
            S_T1M: n_state = i_stat.den1_zero ? S_SHIFT : S_T1D;
            S_T1D: n_state = S_T1W;
            S_T1W: begin
                if (i_stat.div_done) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (last_j) begin
                    n_j = '0;
                    if (last_lvl) begin
                        n_state = S_PSTEP;
                    end else begin
                        n_lvl   = L_W'(r_lvl + L_W'(1));
                        n_state = S_STEP;
                    end
                end else begin
                    n_j     = J_W'(r_j + J_W'(1));
                    n_state = S_STEP;
                end
            end
            S_PSTEP: begin
                n_state = (KA_W'(r_j) < KA_W'(n_eff)) ? S_PRD : S_RCHK;
            end
            S_PRD: begin
                n_c     = CO_X;
                n_state = S_PMUL;
            end
            S_PMUL: n_state = S_PADD;
            S_PADD: begin
                if (r_c == CO_W) begin
                    n_j     = J_W'(r_j + J_W'(1));
                    n_state = S_PSTEP;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_PMUL;
                end
            end
            S_RCHK: begin
                if (i_stat.sw_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_c     = CO_X;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: n_state = S_RWAIT;
            S_RWAIT: begin
                if (i_stat.div_done) begin
                    if (r_c == CO_Z) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + 2'd1;
                        n_state = S_RDIV;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd        = '0;
        o_cmd.k_sel  = r_ks;
        o_cmd.p_addr = PN_W'(r_j);
        o_cmd.coord  = r_c;
        case (r_ks)
            KS_I:    o_cmd.k_addr = KA_W'(r_j);
            KS_ID:   o_cmd.k_addr = j_lvl;
            KS_I1:   o_cmd.k_addr = KA_W'(r_j) + KA_W'(1);
            default: o_cmd.k_addr = j_lvl + KA_W'(1);
        endcase
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_knot  = accept && (i_req_type == REQ_KNOT);
                o_cmd.wr_point = accept && (i_req_type == REQ_POINT);
                o_cmd.u_ld     = accept && (i_req_type == REQ_EVAL);
            end
            S_STEP:  o_cmd.t_clr  = 1'b1;
            S_KRD:   o_cmd.k_rd   = 1'b1;
            S_KCAP:  o_cmd.k_cap  = 1'b1;
            S_T0M:   o_cmd.mul_lo = !i_stat.den0_zero;
            S_T0D:   o_cmd.div_t0 = 1'b1;
            S_T0W:   o_cmd.t_add  = i_stat.div_done;
            S_T1M:   o_cmd.mul_hi = !i_stat.den1_zero;
            S_T1D:   o_cmd.div_t1 = 1'b1;
            S_T1W:   o_cmd.t_add  = i_stat.div_done;
            S_SHIFT: begin
                o_cmd.b_shift = 1'b1;
                o_cmd.b_sel   = shift_sel;
                o_cmd.a_clr   = last_j && last_lvl;
            end
            S_PRD:   o_cmd.p_rd  = 1'b1;
            S_PMUL:  o_cmd.p_mul = 1'b1;
            S_PADD: begin
                o_cmd.a_add   = 1'b1;
                o_cmd.b_shift = (r_c == CO_W);
                o_cmd.b_sel   = BS_KEEP;
            end
            S_RDIV:  o_cmd.div_r = 1'b1;
            S_RWAIT: o_cmd.r_ld  = i_stat.div_done;
            S_DONE:  o_cmd.o_ld  = out_free;
            default: o_cmd.t_clr = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ dv/nurbs_curve_point_eval_tb.sv @@
// ============================================================================
// nurbs_curve_point_eval_tb
// Self-checking bench for the NURBS curve point evaluator: loads knots and
// control points, sweeps degree and point count, and checks every evaluated
// point against a fixed-point Cox-de Boor predictor kept inside the bench.
// ============================================================================
module nurbs_curve_point_eval_tb;
    import ncp_pkg::*;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam longint            CYCLE_LIMIT = 64'd60_000_000;
    localparam int                DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      wz;
    } curve_pt_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [REQ_W-1:0]            i_req_type = '0;
    logic [SLOT_W-1:0]           i_slot = '0;
    logic [PARAM_W-1:0]          i_param_value = '0;
    logic signed [COORD_W-1:0]   i_point_x = '0;
    logic signed [COORD_W-1:0]   i_point_y = '0;
    logic signed [COORD_W-1:0]   i_point_z = '0;
    logic signed [COORD_W-1:0]   i_point_w = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [COORD_W-1:0]   o_curve_x;
    logic signed [COORD_W-1:0]   o_curve_y;
    logic signed [COORD_W-1:0]   o_curve_z;
    logic                        o_weight_zero;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    // Shadow copies of the block's stores and registers.
    longint      knot_mem [MAX_KNOTS];
    longint      px_mem [MAX_POINTS];
    longint      py_mem [MAX_POINTS];
    longint      pz_mem [MAX_POINTS];
    longint      pw_mem [MAX_POINTS];
    int unsigned degree_reg = DEG_RESET;
    int unsigned count_reg = PTS_RESET;

    curve_pt_t   pending_points[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycle_count = 0;

    nurbs_curve_point_eval u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: the run ends with a mismatch once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nurbs_curve_point_eval: mismatch");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint knot_value(input int unsigned idx);
        return (idx < MAX_KNOTS) ? knot_mem[idx] : 0;
    endfunction

    // Rational curve point at parameter u from the shadow stores. Basis values
    // are Q1.30; each recursion term truncates toward zero, and a zero knot
    // span drops its term.
    function automatic curve_pt_t curve_at(input logic [PARAM_W-1:0] u);
        longint      basis [BASIS_LEN];
        longint      t, lo_k, hi_k, ki, kid, ki1, kid1, acc;
        longint      sx, sy, sz, sw;
        int unsigned n, deg, total;
        curve_pt_t   r;
        n = (count_reg > MAX_POINTS) ? MAX_POINTS : count_reg;
        deg = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
        total = n + deg;
        t = longint'(u);
        sx = 0; sy = 0; sz = 0; sw = 0;
        for (int j = 0; j < total; j++) begin
            lo_k = knot_value(j);
            hi_k = knot_value(j + 1);
            basis[j] = (lo_k <= t && t < hi_k) ? 64'sd1073741824 : 0;
        end
        for (int d = 1; d <= deg; d++) begin
            for (int j = 0; j + d < total; j++) begin
                ki = knot_value(j);
                kid = knot_value(j + d);
                ki1 = knot_value(j + 1);
                kid1 = knot_value(j + d + 1);
                acc = 0;
                if (kid != ki) acc += (basis[j] * (t - ki)) / (kid - ki);
                if (kid1 != ki1) acc += (basis[j + 1] * (kid1 - t)) / (kid1 - ki1);
                basis[j] = clamp32(acc);
            end
        end
        for (int j = 0; j < n; j++) begin
            sx += (basis[j] * px_mem[j]) / 64'sd1073741824;
            sy += (basis[j] * py_mem[j]) / 64'sd1073741824;
            sz += (basis[j] * pz_mem[j]) / 64'sd1073741824;
            sw += (basis[j] * pw_mem[j]) / 64'sd1073741824;
        end
        if (sw == 0) begin
            r.x = '0; r.y = '0; r.z = '0; r.wz = 1'b1;
        end else begin
            r.x = COORD_W'(clamp32((sx * 65536) / sw));
            r.y = COORD_W'(clamp32((sy * 65536) / sw));
            r.z = COORD_W'(clamp32((sz * 65536) / sw));
            r.wz = 1'b0;
        end
        return r;
    endfunction

    // Result side: compare each accepted point with the oldest prediction and
    // stall at the current rate.
    always @(posedge i_clk) begin
        curve_pt_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h wz=%b", $time,
                         o_curve_x, o_curve_y, o_curve_z, o_weight_zero);
                fail_count++;
            end else begin
                e = pending_points.pop_front();
                if (o_curve_x !== e.x || o_curve_y !== e.y || o_curve_z !== e.z ||
                    o_weight_zero !== e.wz) begin
                    $display("%0t: expected x=%h y=%h z=%h wz=%b, got x=%h y=%h z=%h wz=%b",
                             $time, e.x, e.y, e.z, e.wz,
                             o_curve_x, o_curve_y, o_curve_z, o_weight_zero);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one request after any idle gap decided here, with valid low through the gap,
    // and update the shadow state when the block takes it. Called at a clock edge.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                            input logic [PARAM_W-1:0] pv,
                            input logic signed [COORD_W-1:0] x, y, z, w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_slot <= slot;
        i_param_value <= pv;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        i_point_w <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == REQ_KNOT && slot < MAX_KNOTS) begin
            knot_mem[slot] = pv;
        end else if (kind == REQ_POINT && slot < MAX_POINTS) begin
            px_mem[slot] = x; py_mem[slot] = y; pz_mem[slot] = z; pw_mem[slot] = w;
        end else if (kind == REQ_EVAL) begin
            pending_points = {pending_points, curve_at(pv)};
        end
    endtask

    task automatic eval_at(input logic [PARAM_W-1:0] u);
        send_req(REQ_EVAL, SLOT_W'($urandom_range(31)), u, $urandom, $urandom, $urandom,
                 $urandom);
    endtask

    // Registers change only once the block has drained every result and
    // finished any trailing store write.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEGREE) degree_reg = value & 3;
        else count_reg = value & 31;
    endtask

    // Nondecreasing knot vector with repeated knots now and then, so spans of
    // zero length occur alongside normal ones.
    task automatic load_knots(input int max_step);
        int unsigned k;
        k = $urandom_range(0, 16'hFFFF);
        for (int i = 0; i < MAX_KNOTS; i++) begin
            send_req(REQ_KNOT, SLOT_W'(i), PARAM_W'(k), $urandom, $urandom, $urandom,
                     $urandom);
            if ($urandom_range(3) != 0) k += $urandom_range(1, max_step);
        end
    endtask

    task automatic load_points(input bit wild);
        logic signed [COORD_W-1:0] w;
        for (int i = 0; i < MAX_POINTS; i++) begin
            w = wild ? $urandom : $urandom_range(32'h0000_4000, 32'h0003_0000);
            send_req(REQ_POINT, SLOT_W'(i), PARAM_W'($urandom),
                     wild ? $urandom : $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                     wild ? $urandom : $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                     wild ? $urandom : $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                     w);
        end
    endtask

    function automatic logic [PARAM_W-1:0] pick_u();
        int unsigned lo, hi;
        lo = 32'(knot_mem[0]);
        hi = 32'(knot_mem[MAX_KNOTS-1]);
        if ($urandom_range(9) == 0) return PARAM_W'($urandom);
        if (hi <= lo) return PARAM_W'(lo);
        return PARAM_W'($urandom_range(lo, hi));
    endfunction

    // Uniform knots, then the edges of the parameter range, extreme fields,
    // ignored writes, an unknown request code and a decreasing knot.
    task automatic test_directed();
        for (int i = 0; i < MAX_KNOTS; i++)
            send_req(REQ_KNOT, SLOT_W'(i), PARAM_W'(i * 32'h0001_0000), '0, '0, '0, '0);
        for (int i = 0; i < MAX_POINTS; i++)
            send_req(REQ_POINT, SLOT_W'(i), '0, i * 32'sh0001_0000, -i * 32'sh0000_8000,
                     32'sh0002_0000, 32'sh0001_0000);
        eval_at(24'h00_0000);
        eval_at(24'h03_8000);
        eval_at(24'h05_0000);
        eval_at(24'h06_FFFF);
        eval_at(24'h07_0000);
        eval_at(24'hFF_FFFF);
        // Writes to slots past the stores must leave them untouched.
        send_req(REQ_KNOT, 5'd31, 24'hFF_FFFF, '0, '0, '0, '0);
        send_req(REQ_POINT, 5'd16, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        send_req(REQ_UNKNOWN, 5'd3, 24'h04_0000, '0, '0, '0, '0);
        eval_at(24'h04_0000);
        // Extreme coordinates with a tiny weight force saturation.
        send_req(REQ_POINT, 5'd1, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh0000_0001);
        send_req(REQ_POINT, 5'd2, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000);
        eval_at(24'h02_4000);
        eval_at(24'h03_0000);
        // Decreasing knots.
        send_req(REQ_KNOT, 5'd4, 24'h00_8000, '0, '0, '0, '0);
        eval_at(24'h03_C000);
        eval_at(24'h00_C000);
    endtask

    // Every degree against small, normal, full and out-of-range point counts.
    task automatic test_config_sweep();
        int unsigned counts [6] = '{0, 1, 2, 16, 17, 31};
        load_knots(32'h0002_0000);
        load_points(1'b0);
        for (int d = 0; d < 4; d++) begin
            write_cfg(CFG_DEGREE, d);
            foreach (counts[c]) begin
                write_cfg(CFG_POINTS, counts[c]);
                repeat (2) eval_at(pick_u());
            end
        end
    endtask

    // Mostly well-formed curves with random content; some noise requests.
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 60 == 0) begin
                write_cfg(CFG_DEGREE, ($urandom_range(3) == 0) ? $urandom_range(3) : 3);
                write_cfg(CFG_POINTS, ($urandom_range(7) == 0) ? $urandom_range(31)
                                                                 : $urandom_range(1, 16));
            end
            case ($urandom_range(19))
                0: begin
                    load_knots(($urandom_range(1)) ? 32'h0001_0000 : 32'h0008_0000);
                    sent += MAX_KNOTS;
                end
                1: begin
                    load_points($urandom_range(3) == 0);
                    sent += MAX_POINTS;
                end
                2: begin
                    send_req(REQ_W'($urandom_range(3)), SLOT_W'($urandom_range(31)),
                             PARAM_W'($urandom), $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
                3, 4: begin
                    send_req(REQ_POINT, SLOT_W'($urandom_range(MAX_POINTS - 1)),
                             PARAM_W'($urandom), $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
                5: begin
                    send_req(REQ_KNOT, SLOT_W'($urandom_range(MAX_KNOTS - 1)),
                             PARAM_W'($urandom), $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
                default: begin
                    eval_at(pick_u());
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        foreach (knot_mem[i]) knot_mem[i] = 0;
        foreach (px_mem[i]) begin
            px_mem[i] = 0; py_mem[i] = 0; pz_mem[i] = 0; pw_mem[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_random(520, 18, 67);
        test_random(520, 67, 18);
        test_random(520, 0, 0);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("nurbs_curve_point_eval: match");
        end else begin
            $display("nurbs_curve_point_eval: mismatch");
        end
        $finish;
    end

endmodule
